// ===== hdl/lazy_range_add_sum_tree_defines.svh =====
// Assertion macros shared by the lazy range add / sum tree RTL.
// Define ASSERT_OFF to compile every check away.
`ifndef LAZY_RANGE_ADD_SUM_TREE_DEFINES_SVH
`define LAZY_RANGE_ADD_SUM_TREE_DEFINES_SVH

`ifndef ASSERT_OFF

// Plain condition, checked at every clock edge out of reset
`define LRAST_ASSERT(LBL, CLK, RSTN, COND) \
  LBL: assert property (@(posedge CLK) disable iff (!RSTN) (COND)) \
    else $error("LRAST check failed");

// Same-cycle implication
`define LRAST_ASSERT_IMP(LBL, CLK, RSTN, ANTE, CONS) \
  LBL: assert property (@(posedge CLK) disable iff (!RSTN) (ANTE) |-> (CONS)) \
    else $error("LRAST implication failed");

`else

`define LRAST_ASSERT(LBL, CLK, RSTN, COND)
`define LRAST_ASSERT_IMP(LBL, CLK, RSTN, ANTE, CONS)

`endif

`endif

// ===== hdl/lrast_pkg.sv =====
// Shared constants, types and helpers of the lazy range add / sum tree.
// No dependencies.
`default_nettype none

package lrast_pkg;

  localparam int LEAF_COUNT  = 1024;
  localparam int NODES       = 2 * LEAF_COUNT;
  localparam int NODE_AW     = $clog2(NODES);
  localparam int POS_W       = 10;
  localparam int VAL_W       = 30;
  localparam int EPOCH_W     = 16;
  localparam int CNT_W       = POS_W + 1;
  localparam int STACK_DEPTH = $clog2(LEAF_COUNT);
  localparam int SP_W        = $clog2(STACK_DEPTH + 1);
  localparam int MODE_W      = 2;

  localparam logic [VAL_W-1:0] MODP = 30'd998244353;
  localparam logic [POS_W-1:0] SPAN_RST = 10'd1023;

  localparam logic [MODE_W-1:0] MODE_CLR = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ADD = 2'd1;
  localparam logic [MODE_W-1:0] MODE_QRY = 2'd2;

  // read address select
  localparam logic [1:0] RS_SELF  = 2'd0;
  localparam logic [1:0] RS_LEFT  = 2'd1;
  localparam logic [1:0] RS_RIGHT = 2'd2;

  // write select
  localparam logic [2:0] WS_COVER   = 3'd0;
  localparam logic [2:0] WS_CHILD_L = 3'd1;
  localparam logic [2:0] WS_CHILD_R = 3'd2;
  localparam logic [2:0] WS_PARENT  = 3'd3;
  localparam logic [2:0] WS_COMB    = 3'd4;
  localparam logic [2:0] WS_SWEEP   = 3'd5;

  // multiplier count select
  localparam logic [1:0] MS_COVER = 2'd0;
  localparam logic [1:0] MS_LEFT  = 2'd1;
  localparam logic [1:0] MS_RIGHT = 2'd2;

  typedef struct packed {
    logic [EPOCH_W-1:0] stamp;
    logic [VAL_W-1:0]   tag;
    logic [VAL_W-1:0]   sum;
  } node_t;

  typedef struct packed {
    logic [NODE_AW-1:0] node;
    logic [POS_W-1:0]   a;
    logic [POS_W-1:0]   b;
    logic [POS_W-1:0]   l;
    logic [POS_W-1:0]   r;
    logic               dir;
  } frame_t;

  typedef struct packed {
    logic       accept;
    logic       init;
    logic       epoch_inc;
    logic       rd_en;
    logic [1:0] rsel;
    logic       wr_en;
    logic [2:0] wsel;
    logic       mul_start;
    logic [1:0] msel;
    logic       lat_node;
    logic       lat_child;
    logic       acc_add;
    logic       push_desc;
    logic       desc_dir;
    logic       pop;
    logic       sweep;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              err;
    logic              empty;
    logic              wrap;
    logic              covered;
    logic              go_l;
    logic              go_r;
    logic              was_right;
    logic              tag_zero;
    logic              mul_busy;
    logic              sp_zero;
    logic              sweep_last;
    logic              out_free;
  } st_t;

  // (a + b) mod P for a, b < P
  function automatic logic [VAL_W-1:0] modadd(input logic [VAL_W-1:0] x,
                                              input logic [VAL_W-1:0] y);
    logic [VAL_W:0] s;
    s = {1'b0, x} + {1'b0, y};
    if (s >= {1'b0, MODP}) begin
      s = s - {1'b0, MODP};
    end
    return s[VAL_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== hdl/lrast_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module lrast_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hdl/lrast_mulmod.sv =====
// Bit-serial modular multiplier: count times value mod P, MSB first, one bit a cycle.
// Depends on lrast_pkg.
`default_nettype none

module lrast_mulmod (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [lrast_pkg::CNT_W-1:0]   cnt,
  input  wire logic [lrast_pkg::VAL_W-1:0]   x,
  output logic                               busy,
  output logic      [lrast_pkg::VAL_W-1:0]   prod
);

  localparam int STEP_W = $clog2(lrast_pkg::CNT_W);

  logic                          busy_r, busy_nxt;
  logic [STEP_W-1:0]             step_r, step_nxt;
  logic [lrast_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [lrast_pkg::VAL_W-1:0]   x_r, x_nxt;
  logic [lrast_pkg::VAL_W-1:0]   acc_r, acc_nxt;
  logic [lrast_pkg::VAL_W-1:0]   dbl;

  always_comb begin
    busy_nxt = busy_r;
    step_nxt = step_r;
    cnt_nxt  = cnt_r;
    x_nxt    = x_r;
    acc_nxt  = acc_r;
    dbl      = lrast_pkg::modadd(acc_r, acc_r);
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = STEP_W'(lrast_pkg::CNT_W - 1);
      cnt_nxt  = cnt;
      x_nxt    = x;
      acc_nxt  = '0;
    end else if (busy_r) begin
      acc_nxt = lrast_pkg::modadd(dbl, cnt_r[lrast_pkg::CNT_W-1] ? x_r : '0);
      cnt_nxt = {cnt_r[lrast_pkg::CNT_W-2:0], 1'b0};
      if (step_r == '0) begin
        busy_nxt = 1'b0;
      end else begin
        step_nxt = step_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      step_r <= step_nxt;
    end
    cnt_r <= cnt_nxt;
    x_r   <= x_nxt;
    acc_r <= acc_nxt;
  end

  assign busy = busy_r;
  assign prod = acc_r;

endmodule

`default_nettype wire

// ===== hdl/lrast_dp.sv =====
// Datapath: item registers, node memory, traversal frame and stack, result register.
// Depends on lrast_pkg, lrast_ram, lrast_mulmod and the assertion macro header.
`default_nettype none
`include "lazy_range_add_sum_tree_defines.svh"

module lrast_dp (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire lrast_pkg::cmd_t               cmd,
  output lrast_pkg::st_t                     st,
  input  wire logic [lrast_pkg::MODE_W-1:0]  in_mode,
  input  wire logic [lrast_pkg::POS_W-1:0]   in_lo,
  input  wire logic [lrast_pkg::POS_W-1:0]   in_hi,
  input  wire logic [lrast_pkg::VAL_W-1:0]   in_addend,
  input  wire logic                          cfg_we,
  input  wire logic [lrast_pkg::POS_W-1:0]   cfg_span,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic      [lrast_pkg::VAL_W-1:0]   out_sum,
  output logic                               out_err
);

  logic [lrast_pkg::POS_W-1:0]   span_r;
  logic [lrast_pkg::MODE_W-1:0]  mode_r;
  logic [lrast_pkg::POS_W-1:0]   lo_r, hi_r;
  logic [lrast_pkg::VAL_W-1:0]   d_r;
  logic [lrast_pkg::EPOCH_W-1:0] epoch_r;
  logic [lrast_pkg::VAL_W-1:0]   acc_r;
  logic [lrast_pkg::VAL_W-1:0]   eff_sum_r, eff_tag_r, ceff_sum_r, ceff_tag_r;
  logic [lrast_pkg::NODE_AW-1:0] node_r;
  logic [lrast_pkg::POS_W-1:0]   a_r, b_r, l_r, r_r;
  logic                          was_right_r;
  logic [lrast_pkg::SP_W-1:0]    sp_r;
  lrast_pkg::frame_t             stack_r [lrast_pkg::STACK_DEPTH];
  logic [lrast_pkg::NODE_AW-1:0] sweep_r;
  logic                          out_valid_r;
  logic [lrast_pkg::VAL_W-1:0]   out_sum_r;
  logic                          out_err_r;

  logic [lrast_pkg::POS_W:0]     ab_sum;
  logic [lrast_pkg::POS_W-1:0]   mid;
  logic [lrast_pkg::NODE_AW-1:0] left_n, right_n;
  logic                          err_w;
  logic [$bits(lrast_pkg::node_t)-1:0] rdata;
  lrast_pkg::node_t              dout, wnode;
  logic [lrast_pkg::VAL_W-1:0]   dsum_eff, dtag_eff;
  logic [lrast_pkg::NODE_AW-1:0] raddr, waddr;
  logic                          we;
  logic [lrast_pkg::CNT_W-1:0]   mcnt;
  logic [lrast_pkg::VAL_W-1:0]   mx, prod;
  logic                          mbusy;
  lrast_pkg::frame_t             top_f;

  assign ab_sum  = {1'b0, a_r} + {1'b0, b_r};
  assign mid     = ab_sum[lrast_pkg::POS_W:1];
  assign left_n  = {node_r[lrast_pkg::NODE_AW-2:0], 1'b0};
  assign right_n = {node_r[lrast_pkg::NODE_AW-2:0], 1'b1};
  assign err_w   = ((mode_r == lrast_pkg::MODE_ADD) || (mode_r == lrast_pkg::MODE_QRY))
                   && (hi_r > span_r);

  assign dout     = lrast_pkg::node_t'(rdata);
  // a node stamped in an older epoch reads as cleared
  assign dsum_eff = (dout.stamp == epoch_r) ? dout.sum : '0;
  assign dtag_eff = (dout.stamp == epoch_r) ? dout.tag : '0;
  assign top_f    = stack_r[sp_r - 1'b1];

  always_comb begin
    case (cmd.rsel)
      lrast_pkg::RS_LEFT:  raddr = left_n;
      lrast_pkg::RS_RIGHT: raddr = right_n;
      default:             raddr = node_r;
    endcase
  end

  always_comb begin
    case (cmd.msel)
      lrast_pkg::MS_LEFT: begin
        mcnt = lrast_pkg::CNT_W'({1'b0, mid} - {1'b0, a_r} + 1'b1);
        mx   = eff_tag_r;
      end
      lrast_pkg::MS_RIGHT: begin
        mcnt = lrast_pkg::CNT_W'({1'b0, b_r} - {1'b0, mid});
        mx   = eff_tag_r;
      end
      default: begin
        mcnt = lrast_pkg::CNT_W'({1'b0, b_r} - {1'b0, a_r} + 1'b1);
        mx   = d_r;
      end
    endcase
  end

  always_comb begin
    we          = cmd.wr_en;
    waddr       = node_r;
    wnode.stamp = epoch_r;
    wnode.tag   = '0;
    wnode.sum   = eff_sum_r;
    case (cmd.wsel)
      lrast_pkg::WS_COVER: begin
        wnode.sum = lrast_pkg::modadd(eff_sum_r, prod);
        wnode.tag = lrast_pkg::modadd(eff_tag_r, d_r);
      end
      lrast_pkg::WS_CHILD_L: begin
        waddr     = left_n;
        wnode.sum = lrast_pkg::modadd(ceff_sum_r, prod);
        wnode.tag = lrast_pkg::modadd(ceff_tag_r, eff_tag_r);
      end
      lrast_pkg::WS_CHILD_R: begin
        waddr     = right_n;
        wnode.sum = lrast_pkg::modadd(ceff_sum_r, prod);
        wnode.tag = lrast_pkg::modadd(ceff_tag_r, eff_tag_r);
      end
      lrast_pkg::WS_PARENT: begin
        wnode.sum = eff_sum_r;
      end
      lrast_pkg::WS_COMB: begin
        wnode.sum = lrast_pkg::modadd(ceff_sum_r, dsum_eff);
      end
      lrast_pkg::WS_SWEEP: begin
        waddr       = sweep_r;
        wnode.stamp = '0;
        wnode.sum   = '0;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  lrast_ram #(
    .WIDTH ($bits(lrast_pkg::node_t)),
    .DEPTH (lrast_pkg::NODES)
  ) u_node_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wnode),
    .raddr (raddr),
    .rdata (rdata)
  );

  lrast_mulmod u_mulmod (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.mul_start),
    .cnt   (mcnt),
    .x     (mx),
    .busy  (mbusy),
    .prod  (prod)
  );

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      span_r      <= lrast_pkg::SPAN_RST;
      epoch_r     <= '0;
      sp_r        <= '0;
      sweep_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        span_r <= cfg_span;
      end
      if (cmd.epoch_inc) begin
        epoch_r <= epoch_r + 1'b1;
      end
      if (cmd.init) begin
        sp_r <= '0;
      end else if (cmd.push_desc) begin
        sp_r <= sp_r + 1'b1;
      end else if (cmd.pop) begin
        sp_r <= sp_r - 1'b1;
      end
      if (cmd.sweep) begin
        sweep_r <= sweep_r + 1'b1;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      mode_r <= in_mode;
      lo_r   <= in_lo;
      hi_r   <= in_hi;
      d_r    <= (in_addend >= lrast_pkg::MODP) ? in_addend - lrast_pkg::MODP : in_addend;
      acc_r  <= '0;
    end else if (cmd.acc_add) begin
      acc_r <= lrast_pkg::modadd(acc_r, dsum_eff);
    end
    if (cmd.lat_node) begin
      eff_sum_r <= dsum_eff;
      eff_tag_r <= dtag_eff;
    end
    if (cmd.lat_child) begin
      ceff_sum_r <= dsum_eff;
      ceff_tag_r <= dtag_eff;
    end
    if (cmd.init) begin
      node_r <= lrast_pkg::NODE_AW'(1);
      a_r    <= '0;
      b_r    <= span_r;
      l_r    <= lo_r;
      r_r    <= hi_r;
    end else if (cmd.push_desc) begin
      stack_r[sp_r] <= '{node: node_r, a: a_r, b: b_r, l: l_r, r: r_r, dir: cmd.desc_dir};
      if (!cmd.desc_dir) begin
        node_r <= left_n;
        b_r    <= mid;
        r_r    <= (r_r <= mid) ? r_r : mid;
      end else begin
        node_r <= right_n;
        a_r    <= mid + 1'b1;
        l_r    <= (l_r > mid) ? l_r : mid + 1'b1;
      end
    end else if (cmd.pop) begin
      node_r      <= top_f.node;
      a_r         <= top_f.a;
      b_r         <= top_f.b;
      l_r         <= top_f.l;
      r_r         <= top_f.r;
      was_right_r <= top_f.dir;
    end
    if (cmd.out_load) begin
      out_sum_r <= acc_r;
      out_err_r <= err_w;
    end
  end

  always_comb begin
    st.mode       = mode_r;
    st.err        = err_w;
    st.empty      = lo_r > hi_r;
    st.wrap       = &epoch_r;
    st.covered    = (a_r == l_r) && (b_r == r_r);
    st.go_l       = l_r <= mid;
    st.go_r       = r_r > mid;
    st.was_right  = was_right_r;
    st.tag_zero   = dtag_eff == '0;
    st.mul_busy   = mbusy;
    st.sp_zero    = sp_r == '0;
    st.sweep_last = &sweep_r;
    st.out_free   = !out_valid_r || out_ready;
  end

  assign out_valid = out_valid_r;
  assign out_sum   = out_sum_r;
  assign out_err   = out_err_r;

  `LRAST_ASSERT(a_sp_bound, clk, rst_n, sp_r <= lrast_pkg::SP_W'(lrast_pkg::STACK_DEPTH))
  `LRAST_ASSERT_IMP(a_mul_idle, clk, rst_n, cmd.mul_start, !mbusy)
  `LRAST_ASSERT_IMP(a_pop_nonempty, clk, rst_n, cmd.pop, sp_r != '0)
  `LRAST_ASSERT_IMP(a_err_no_sum, clk, rst_n, out_valid_r && out_err_r, out_sum_r == '0)

endmodule

`default_nettype wire

// ===== hdl/lrast_ctrl.sv =====
// Controller: state machine sequencing the tree walk, pushes, sweeps and results.
// Depends on lrast_pkg.
`default_nettype none

module lrast_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire lrast_pkg::st_t st,
  output lrast_pkg::cmd_t     cmd
);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_START = 5'd1;
  localparam logic [4:0] S_ENTER = 5'd2;
  localparam logic [4:0] S_NODE  = 5'd3;
  localparam logic [4:0] S_CWAIT = 5'd4;
  localparam logic [4:0] S_PRL   = 5'd5;
  localparam logic [4:0] S_PML   = 5'd6;
  localparam logic [4:0] S_PWL   = 5'd7;
  localparam logic [4:0] S_PRR   = 5'd8;
  localparam logic [4:0] S_PMR   = 5'd9;
  localparam logic [4:0] S_PWR   = 5'd10;
  localparam logic [4:0] S_PWP   = 5'd11;
  localparam logic [4:0] S_DESC  = 5'd12;
  localparam logic [4:0] S_DESCR = 5'd13;
  localparam logic [4:0] S_RET   = 5'd14;
  localparam logic [4:0] S_POP   = 5'd15;
  localparam logic [4:0] S_CML   = 5'd16;
  localparam logic [4:0] S_CMR   = 5'd17;
  localparam logic [4:0] S_CMW   = 5'd18;
  localparam logic [4:0] S_DONE  = 5'd19;
  localparam logic [4:0] S_SWEEP = 5'd20;

  logic [4:0] state_r, state_nxt;
  logic       boot_r, boot_nxt;

  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    state_nxt = state_r;
    boot_nxt  = boot_r;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_START;
        end
      end
      S_START: begin
        if (st.mode == lrast_pkg::MODE_CLR) begin
          cmd.epoch_inc = 1'b1;
          state_nxt     = st.wrap ? S_SWEEP : S_DONE;
        end else if ((st.mode == lrast_pkg::MODE_ADD) || (st.mode == lrast_pkg::MODE_QRY)) begin
          if (st.err || st.empty) begin
            state_nxt = S_DONE;
          end else begin
            cmd.init  = 1'b1;
            state_nxt = S_ENTER;
          end
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_ENTER: begin
        cmd.rd_en = 1'b1;
        cmd.rsel  = lrast_pkg::RS_SELF;
        state_nxt = S_NODE;
      end
      S_NODE: begin
        cmd.lat_node = 1'b1;
        if (st.covered) begin
          if (st.mode == lrast_pkg::MODE_ADD) begin
            cmd.mul_start = 1'b1;
            cmd.msel      = lrast_pkg::MS_COVER;
            state_nxt     = S_CWAIT;
          end else begin
            cmd.acc_add = 1'b1;
            state_nxt   = S_RET;
          end
        end else begin
          state_nxt = st.tag_zero ? S_DESC : S_PRL;
        end
      end
      S_CWAIT: begin
        cmd.msel = lrast_pkg::MS_COVER;
        if (!st.mul_busy) begin
          cmd.wr_en = 1'b1;
          cmd.wsel  = lrast_pkg::WS_COVER;
          state_nxt = S_RET;
        end
      end
      S_PRL: begin
        cmd.rd_en = 1'b1;
        cmd.rsel  = lrast_pkg::RS_LEFT;
        state_nxt = S_PML;
      end
      S_PML: begin
        cmd.lat_child = 1'b1;
        cmd.mul_start = 1'b1;
        cmd.msel      = lrast_pkg::MS_LEFT;
        state_nxt     = S_PWL;
      end
      S_PWL: begin
        if (!st.mul_busy) begin
          cmd.wr_en = 1'b1;
          cmd.wsel  = lrast_pkg::WS_CHILD_L;
          state_nxt = S_PRR;
        end
      end
      S_PRR: begin
        cmd.rd_en = 1'b1;
        cmd.rsel  = lrast_pkg::RS_RIGHT;
        state_nxt = S_PMR;
      end
      S_PMR: begin
        cmd.lat_child = 1'b1;
        cmd.mul_start = 1'b1;
        cmd.msel      = lrast_pkg::MS_RIGHT;
        state_nxt     = S_PWR;
      end
      S_PWR: begin
        if (!st.mul_busy) begin
          cmd.wr_en = 1'b1;
          cmd.wsel  = lrast_pkg::WS_CHILD_R;
          state_nxt = S_PWP;
        end
      end
      S_PWP: begin
        cmd.wr_en = 1'b1;
        cmd.wsel  = lrast_pkg::WS_PARENT;
        state_nxt = S_DESC;
      end
      S_DESC: begin
        cmd.push_desc = 1'b1;
        cmd.desc_dir  = !st.go_l;
        state_nxt     = S_ENTER;
      end
      S_DESCR: begin
        cmd.push_desc = 1'b1;
        cmd.desc_dir  = 1'b1;
        state_nxt     = S_ENTER;
      end
      S_RET: begin
        if (st.sp_zero) begin
          state_nxt = S_DONE;
        end else begin
          cmd.pop   = 1'b1;
          state_nxt = S_POP;
        end
      end
      S_POP: begin
        if (!st.was_right && st.go_r) begin
          state_nxt = S_DESCR;
        end else if (st.mode == lrast_pkg::MODE_ADD) begin
          state_nxt = S_CML;
        end else begin
          state_nxt = S_RET;
        end
      end
      S_CML: begin
        cmd.rd_en = 1'b1;
        cmd.rsel  = lrast_pkg::RS_LEFT;
        state_nxt = S_CMR;
      end
      S_CMR: begin
        cmd.lat_child = 1'b1;
        cmd.rd_en     = 1'b1;
        cmd.rsel      = lrast_pkg::RS_RIGHT;
        state_nxt     = S_CMW;
      end
      S_CMW: begin
        cmd.wr_en = 1'b1;
        cmd.wsel  = lrast_pkg::WS_COMB;
        state_nxt = S_RET;
      end
      S_DONE: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_SWEEP: begin
        cmd.sweep = 1'b1;
        cmd.wr_en = 1'b1;
        cmd.wsel  = lrast_pkg::WS_SWEEP;
        if (st.sweep_last) begin
          boot_nxt  = 1'b0;
          state_nxt = boot_r ? S_IDLE : S_DONE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_SWEEP;
      boot_r  <= 1'b1;
    end else begin
      state_r <= state_nxt;
      boot_r  <= boot_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/lazy_range_add_sum_tree.sv =====
// Top level of the lazy range add / range sum tree (modulo 998244353).
// Depends on lrast_pkg, lrast_ctrl, lrast_dp.
// One item at a time. After reset all 2048 node memory entries are swept before the
// first item is taken; a clear wrapping the 16-bit epoch costs the same sweep. Other
// clears and ignored, out-of-range or empty items skip the tree walk. A range operation
// walks the tree one node at a time through a single node RAM, with an add-side recombine
// of the two children on the way back up, two bit-serial modular multiplies for each node
// whose pending tag is pushed down, and one for each covered node of an add.
`default_nettype none

module lazy_range_add_sum_tree (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [55:0] in_tdata,   // lo[9:0], hi[19:10], addend[49:20], zero pad
  input  wire logic [1:0]  in_tuser,   // mode[1:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [31:0] out_tdata,  // sum[29:0], zero pad
  output logic      [0:0]  out_tuser,  // range_error[0]
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [9:0]  cfg_data    // span_high[9:0]
);

  lrast_pkg::cmd_t             cmd;
  lrast_pkg::st_t              st;
  logic [lrast_pkg::VAL_W-1:0] sum;
  logic                        range_error;

  assign cfg_ready = 1'b1;

  lrast_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .st       (st),
    .cmd      (cmd)
  );

  lrast_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .st        (st),
    .in_mode   (in_tuser),
    .in_lo     (in_tdata[9:0]),
    .in_hi     (in_tdata[19:10]),
    .in_addend (in_tdata[49:20]),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_span  (cfg_data),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_sum   (sum),
    .out_err   (range_error)
  );

  assign out_tdata = {2'b00, sum};
  assign out_tuser = range_error;

endmodule

`default_nettype wire
